>>> design/srdc_pkg.sv
`default_nettype none
package srdc_pkg;

  localparam int unsigned ADDRESS_WIDTH_DEF = 64;
  localparam int unsigned BASE_W            = 64;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned MAG_W             = 31;
  localparam int unsigned SPAN_W            = 2 * MAG_W;
  localparam int unsigned SPAN_LO_W         = 32;
  localparam int unsigned SPAN_HI_W         = SPAN_W - SPAN_LO_W;
  localparam int unsigned BYTES_FULL_W      = SPAN_W + MAG_W;
  localparam int unsigned EXT_STAGES        = 4;

  localparam logic [WORD_W-1:0] STRIDE_MOST_NEG = 32'h8000_0000;

endpackage
`default_nettype wire

>>> design/srdc_extent.sv
`default_nettype none
module srdc_extent #(
  parameter int unsigned ADDRESS_WIDTH = srdc_pkg::ADDRESS_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic [srdc_pkg::EXT_STAGES-1:0]       en,
  input  wire logic [srdc_pkg::BASE_W-1:0]           base,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]    count,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]    stride,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]    elem_size,
  output logic [ADDRESS_WIDTH-1:0]                   ext_lo,
  output logic [ADDRESS_WIDTH-1:0]                   ext_hi,
  output logic                                       ext_ok,
  output logic                                       ext_empty
);

  localparam int unsigned AW    = ADDRESS_WIDTH;
  localparam int unsigned MAG_W = srdc_pkg::MAG_W;
  localparam int unsigned SUM_W = ((AW > MAG_W) ? AW : MAG_W) + 2;
  localparam int unsigned BF_W  = srdc_pkg::BYTES_FULL_W;

  // Stage 1: decode and first product (count-1) * |stride|.
  logic                       bad_nxt, neg_nxt, empty_nxt;
  logic [MAG_W-1:0]           mag_nxt, cm1_nxt;
  logic [srdc_pkg::SPAN_W-1:0] span_nxt;

  assign empty_nxt = (count == '0);
  assign bad_nxt   = count[srdc_pkg::WORD_W-1] | elem_size[srdc_pkg::WORD_W-1] |
                     (elem_size == '0) | (stride == srdc_pkg::STRIDE_MOST_NEG);
  assign neg_nxt   = stride[srdc_pkg::WORD_W-1];
  assign mag_nxt   = neg_nxt ? (~stride[MAG_W-1:0] + MAG_W'(1)) : stride[MAG_W-1:0];
  assign cm1_nxt   = count[MAG_W-1:0] - MAG_W'(1);
  assign span_nxt  = cm1_nxt * mag_nxt;

  logic [srdc_pkg::SPAN_W-1:0] s1_span_r;
  logic [AW-1:0]               s1_base_r;
  logic [MAG_W-1:0]            s1_esz_r;
  logic                        s1_neg_r, s1_bad_r, s1_empty_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_span_r  <= span_nxt;
      s1_base_r  <= base[AW-1:0];
      s1_esz_r   <= elem_size[MAG_W-1:0];
      s1_neg_r   <= neg_nxt;
      s1_bad_r   <= bad_nxt;
      s1_empty_r <= empty_nxt;
    end
  end

  // Stage 2: span * size as two partial products.
  logic [srdc_pkg::SPAN_LO_W+MAG_W-1:0] pl_nxt;
  logic [srdc_pkg::SPAN_HI_W+MAG_W-1:0] ph_nxt;

  assign pl_nxt = s1_span_r[srdc_pkg::SPAN_LO_W-1:0] * s1_esz_r;
  assign ph_nxt = s1_span_r[srdc_pkg::SPAN_W-1:srdc_pkg::SPAN_LO_W] * s1_esz_r;

  logic [srdc_pkg::SPAN_LO_W+MAG_W-1:0] s2_pl_r;
  logic [srdc_pkg::SPAN_HI_W+MAG_W-1:0] s2_ph_r;
  logic [AW-1:0]                        s2_base_r;
  logic [MAG_W-1:0]                     s2_esz_r;
  logic                                 s2_neg_r, s2_bad_r, s2_empty_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_pl_r    <= pl_nxt;
      s2_ph_r    <= ph_nxt;
      s2_base_r  <= s1_base_r;
      s2_esz_r   <= s1_esz_r;
      s2_neg_r   <= s1_neg_r;
      s2_bad_r   <= s1_bad_r;
      s2_empty_r <= s1_empty_r;
    end
  end

  // Stage 3: combine partial products and check the byte span fits.
  logic [BF_W-1:0] bytes_full;
  logic            ovf_nxt;

  assign bytes_full = {s2_ph_r, {srdc_pkg::SPAN_LO_W{1'b0}}} + BF_W'(s2_pl_r);
  assign ovf_nxt    = |bytes_full[BF_W-1:AW];

  logic [AW-1:0]    s3_bytes_r, s3_base_r;
  logic [MAG_W-1:0] s3_esz_r;
  logic             s3_neg_r, s3_bad_r, s3_empty_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_bytes_r <= bytes_full[AW-1:0];
      s3_base_r  <= s2_base_r;
      s3_esz_r   <= s2_esz_r;
      s3_neg_r   <= s2_neg_r;
      s3_bad_r   <= s2_bad_r | ovf_nxt;
      s3_empty_r <= s2_empty_r;
    end
  end

  // Stage 4: place the extent and check the address arithmetic.
  logic [SUM_W-1:0] base_x, bytes_x, esz_x, top_neg, top_pos;
  logic             ok_nxt;
  logic [AW-1:0]    lo_nxt, hi_nxt;

  assign base_x  = SUM_W'(s3_base_r);
  assign bytes_x = SUM_W'(s3_bytes_r);
  assign esz_x   = SUM_W'(s3_esz_r);
  assign top_neg = base_x + esz_x;
  assign top_pos = base_x + bytes_x + esz_x;

  always_comb begin
    if (s3_neg_r) begin
      ok_nxt = !s3_bad_r && (s3_bytes_r <= s3_base_r) && !(|top_neg[SUM_W-1:AW]);
      lo_nxt = s3_base_r - s3_bytes_r;
      hi_nxt = top_neg[AW-1:0];
    end else begin
      ok_nxt = !s3_bad_r && !(|top_pos[SUM_W-1:AW]);
      lo_nxt = s3_base_r;
      hi_nxt = top_pos[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ext_lo    <= lo_nxt;
      ext_hi    <= hi_nxt;
      ext_ok    <= ok_nxt;
      ext_empty <= s3_empty_r;
    end
  end

endmodule
`default_nettype wire

>>> design/strided_range_disjoint_check.sv
`default_nettype none
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   first_* and second_* descriptors
// out_     output     out_valid/out_stall disjoint
//
// One transaction can be accepted every cycle while in_stall is low; each
// result passes through four extent stages and then the compare stage.
// Reset (rst_n low at a clock edge) empties the pipeline valid bits.
// A stall on the output fills bubbles first; in_stall rises only when every
// stage holds a transaction.
module strided_range_disjoint_check #(
  parameter int unsigned ADDRESS_WIDTH = srdc_pkg::ADDRESS_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [srdc_pkg::BASE_W-1:0]         in_first_base,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]  in_first_count,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]  in_first_stride,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]  in_first_elem_size,
  input  wire logic [srdc_pkg::BASE_W-1:0]         in_second_base,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]  in_second_count,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]  in_second_stride,
  input  wire logic signed [srdc_pkg::WORD_W-1:0]  in_second_elem_size,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_disjoint
);

  localparam int unsigned NS = srdc_pkg::EXT_STAGES;

  logic [NS-1:0]            v_r;
  logic [NS-1:0]            en;
  logic                     en_out;
  logic                     out_valid_r, out_disjoint_r;
  logic [ADDRESS_WIDTH-1:0] a_lo, a_hi, b_lo, b_hi;
  logic                     a_ok, b_ok, a_empty, b_empty;
  logic                     disjoint_nxt;

  assign en_out = !out_valid_r || !out_stall;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || en_out;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (en_out) begin
        out_valid_r <= v_r[NS-1];
      end
    end
  end

  srdc_extent #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_first (
    .clk       (clk),
    .en        (en),
    .base      (in_first_base),
    .count     (in_first_count),
    .stride    (in_first_stride),
    .elem_size (in_first_elem_size),
    .ext_lo    (a_lo),
    .ext_hi    (a_hi),
    .ext_ok    (a_ok),
    .ext_empty (a_empty)
  );

  srdc_extent #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_second (
    .clk       (clk),
    .en        (en),
    .base      (in_second_base),
    .count     (in_second_count),
    .stride    (in_second_stride),
    .elem_size (in_second_elem_size),
    .ext_lo    (b_lo),
    .ext_hi    (b_hi),
    .ext_ok    (b_ok),
    .ext_empty (b_empty)
  );

  assign disjoint_nxt = a_empty || b_empty ||
                        (a_ok && b_ok && ((a_hi <= b_lo) || (b_hi <= a_lo)));

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_disjoint_r <= disjoint_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_disjoint = out_disjoint_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_valid_r && out_stall))
    else $error("input stalled while the pipeline had a free stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted transaction did not enter the first stage");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && en_out) |=> out_valid_r)
    else $error("transaction lost between the last stage and the output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (v_r == '0)))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_W = srdc_pkg::ADDRESS_WIDTH_DEF;
  localparam logic [127:0] ADDR_MAX = (128'd1 << ADDR_W) - 128'd1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [63:0] base;
    logic [31:0] count;
    logic [31:0] stride;
    logic [31:0] elem_size;
  } stream_t;

  typedef struct packed {
    stream_t first;
    stream_t second;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pair_t offer = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_disjoint;

  pair_t descriptor_queue[$];
  bit disjoint_expected[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit wanted;

  strided_range_disjoint_check u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_base       (offer.first.base),
    .in_first_count      (offer.first.count),
    .in_first_stride     (offer.first.stride),
    .in_first_elem_size  (offer.first.elem_size),
    .in_second_base      (offer.second.base),
    .in_second_count     (offer.second.count),
    .in_second_stride    (offer.second.stride),
    .in_second_elem_size (offer.second.elem_size),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_disjoint        (out_disjoint)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic stream_t strm(logic [63:0] base, logic [31:0] count,
                                   logic [31:0] stride, logic [31:0] elem_size);
    stream_t s;
    s.base = base;
    s.count = count;
    s.stride = stride;
    s.elem_size = elem_size;
    return s;
  endfunction

  // Works out the byte extent [lo, hi) of one stream, or returns 0 when the
  // descriptor is invalid or the extent does not fit the address space.
  function automatic bit stream_extent(stream_t s, output logic [63:0] lo,
                                       output logic [63:0] hi);
    logic [127:0] addr;
    logic [127:0] span;
    logic [127:0] bytes_total;
    logic [127:0] top;
    logic [31:0] mag;
    bit neg;
    lo = '0;
    hi = '0;
    addr = 128'(s.base) & ADDR_MAX;
    if (s.count[31] || s.elem_size == 32'd0 || s.elem_size[31] ||
        s.stride == srdc_pkg::STRIDE_MOST_NEG) begin
      return 1'b0;
    end
    neg = s.stride[31];
    mag = neg ? (~s.stride + 32'd1) : s.stride;
    span = 128'(s.count - 32'd1) * 128'(mag);
    if (span > ADDR_MAX) begin
      return 1'b0;
    end
    bytes_total = span * 128'(s.elem_size);
    if (bytes_total > ADDR_MAX) begin
      return 1'b0;
    end
    if (neg) begin
      if (bytes_total > addr) begin
        return 1'b0;
      end
      top = addr + 128'(s.elem_size);
      if (top > ADDR_MAX) begin
        return 1'b0;
      end
      lo = 64'(addr - bytes_total);
      hi = 64'(top);
      return 1'b1;
    end
    top = addr + bytes_total;
    if (top > ADDR_MAX) begin
      return 1'b0;
    end
    top = top + 128'(s.elem_size);
    if (top > ADDR_MAX) begin
      return 1'b0;
    end
    lo = 64'(addr);
    hi = 64'(top);
    return 1'b1;
  endfunction

  function automatic bit ranges_disjoint(pair_t p);
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
    if (p.first.count == 32'd0 || p.second.count == 32'd0) begin
      return 1'b1;
    end
    if (!stream_extent(p.first, a_lo, a_hi)) begin
      return 1'b0;
    end
    if (!stream_extent(p.second, b_lo, b_hi)) begin
      return 1'b0;
    end
    return (a_hi <= b_lo) || (b_hi <= a_lo);
  endfunction

  function automatic stream_t random_stream(logic [63:0] anchor);
    stream_t s;
    int unsigned kind;
    kind = $urandom_range(0, 19);
    s.base = anchor + 64'($urandom_range(0, 600));
    s.count = 32'($urandom_range(1, 40));
    s.stride = 32'($urandom_range(0, 16)) - 32'd8;
    s.elem_size = 32'd1 << $urandom_range(0, 4);
    if (kind == 14 || kind == 15) begin
      s.count = 32'd0;
      s.stride = $urandom;
      s.elem_size = $urandom;
    end else if (kind == 16 || kind == 17) begin
      s.base = {$urandom, $urandom};
      s.count = $urandom;
      s.stride = $urandom;
      s.elem_size = $urandom;
    end else if (kind == 18) begin
      case ($urandom_range(0, 3))
        0: s.count = 32'h8000_0000 | $urandom;
        1: s.elem_size = 32'd0;
        2: s.elem_size = 32'h8000_0000 | $urandom;
        default: s.stride = srdc_pkg::STRIDE_MOST_NEG;
      endcase
    end else if (kind == 19) begin
      s.count = $urandom_range(1, 32'h7FFF_FFFF);
      s.stride = $urandom;
      s.elem_size = $urandom_range(1, 32'h7FFF_FFFF);
    end
    return s;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    logic [63:0] anchor;
    case ($urandom_range(0, 5))
      0: anchor = 64'($urandom_range(0, 3000));
      1: anchor = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3000));
      default: anchor = {$urandom, $urandom};
    endcase
    p.first = random_stream(anchor);
    p.second = random_stream(anchor);
    return p;
  endfunction

  task automatic queue_pair(stream_t a, stream_t b);
    pair_t p;
    p.first = a;
    p.second = b;
    descriptor_queue.push_back(p);
  endtask

  task automatic wait_for_idle();
    while (descriptor_queue.size() != 0 || in_valid || disjoint_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        disjoint_expected.push_back(ranges_disjoint(offer));
      end
      if (!in_valid || !in_stall) begin
        if (descriptor_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offer <= descriptor_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (disjoint_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected transaction: disjoint=%0b", out_disjoint);
        end
      end else begin
        wanted = disjoint_expected.pop_front();
        if (out_disjoint !== wanted) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch on disjoint: expected %0b, got %0b", wanted, out_disjoint);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 23;
    recv_stall_pct = 65;
    queue_pair(strm(64'd100, 32'd0, 32'd1, 32'd4), strm(64'd100, 32'd4, 32'd1, 32'd4));
    queue_pair(strm(64'd0, 32'hFFFF_FFFF, 32'd1, 32'd4), strm(64'd0, 32'd0, 32'd0, 32'd0));
    queue_pair(strm(64'd0, 32'hFFFF_FFFB, 32'd1, 32'd4), strm(64'd1000, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'd0, 32'd3, 32'd1, 32'd0), strm(64'd1000, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'd0, 32'd3, 32'd1, 32'h8000_0000), strm(64'd1000, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'd0, 32'd3, srdc_pkg::STRIDE_MOST_NEG, 32'd4),
               strm(64'd1000, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'd0, 32'd1, srdc_pkg::STRIDE_MOST_NEG, 32'd4),
               strm(64'd1000, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'd0, 32'd1, 32'd1, 32'd1), strm(64'd10, 32'd1, 32'd1, 32'd0));
    queue_pair(strm(64'd100, 32'd4, 32'd1, 32'd4), strm(64'd110, 32'd2, 32'd1, 32'd4));
    queue_pair(strm(64'd100, 32'd4, 32'd1, 32'd4), strm(64'd116, 32'd1, 32'd0, 32'd8));
    queue_pair(strm(64'd100, 32'd4, 32'd1, 32'd4), strm(64'd115, 32'd1, 32'd0, 32'd8));
    queue_pair(strm(64'd1000, 32'd4, 32'hFFFF_FFFE, 32'd8),
               strm(64'd900, 32'd13, 32'd1, 32'd4));
    queue_pair(strm(64'd1000, 32'd4, 32'hFFFF_FFFE, 32'd8),
               strm(64'd900, 32'd14, 32'd1, 32'd4));
    queue_pair(strm(64'd10, 32'd4, 32'hFFFF_FFFF, 32'd8), strm(64'd500, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'hFFFF_FFFF_FFFF_FFFC, 32'd1, 32'hFFFF_FFFF, 32'd8),
               strm(64'd0, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'hFFFF_FFFF_FFFF_FFF0, 32'd2, 32'd1, 32'd16),
               strm(64'd0, 32'd1, 32'd1, 32'd4));
    queue_pair(strm(64'hFFFF_FFFF_FFFF_FFEF, 32'd2, 32'd1, 32'd8),
               strm(64'd0, 32'd1, 32'd0, 32'd1));
    queue_pair(strm(64'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
               strm(64'd0, 32'd1, 32'd1, 32'd1));
    queue_pair(strm(64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'd1),
               strm(64'd0, 32'd2, 32'd1, 32'd4));
    queue_pair(strm(64'd50, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF),
               strm(64'd0, 32'd1, 32'd1, 32'd50));
    queue_pair(strm(64'd0, 32'd1, 32'd1, 32'd8), strm(64'd0, 32'd1, 32'd1, 32'd8));
    queue_pair(strm(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
               strm(64'd0, 32'd0, 32'd0, 32'd0));
    queue_pair(strm(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1),
               strm(64'd0, 32'd1, 32'd1, 32'd1));
    queue_pair(strm(64'd200, 32'd1, 32'd1, 32'd8), strm(64'd100, 32'd25, 32'd1, 32'd4));
    repeat (340) descriptor_queue.push_back(random_pair());
    wait_for_idle();

    send_idle_pct = 65;
    recv_stall_pct = 23;
    repeat (340) descriptor_queue.push_back(random_pair());
    wait_for_idle();

    // The receiver holds off for a long stretch at the start of this phase so
    // that the pipeline fills and pushes back on the sender.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b1;
    repeat (370) descriptor_queue.push_back(random_pair());
    wait_for_idle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && disjoint_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> strided_range_disjoint_check.f
design/srdc_pkg.sv
design/srdc_extent.sv
design/strided_range_disjoint_check.sv
sim/tb.sv
